// ===== rtl/core/i2p_pkg.sv =====
`default_nettype none

package i2p_pkg;

  // store and stack depth; counts reach DEPTH itself
  localparam int unsigned DEPTH       = 64;
  localparam int unsigned AW          = $clog2(DEPTH);
  localparam int unsigned CW          = $clog2(DEPTH + 1);
  localparam int unsigned MAX_RESULTS = 64;
  localparam int unsigned OUT_LIMIT   = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;

  // token queue between front and back, power of two
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [2:0] {
    TK_OPERAND,
    TK_OPER,
    TK_OPEN,
    TK_CLOSE,
    TK_BLANK,
    TK_BAD,
    TK_END
  } tok_kind_e;

  // TK_END carries the front's error flag in ch[0]
  typedef struct packed {
    tok_kind_e  kind;
    logic [7:0] ch;
  } token_t;

  function automatic logic [1:0] prec(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_DOLLAR) begin
      p = 2'd3;
    end else if (c == CH_STAR || c == CH_SLASH || c == CH_PCT) begin
      p = 2'd2;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      p = 2'd1;
    end
    return p;
  endfunction

  function automatic tok_kind_e classify(input logic [7:0] c);
    tok_kind_e k;
    if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
        (c >= 8'h61 && c <= 8'h7A)) begin
      k = TK_OPERAND;
    end else if (c == CH_SPACE || c == CH_TAB) begin
      k = TK_BLANK;
    end else if (c == CH_RPAR) begin
      k = TK_CLOSE;
    end else if (c == CH_LPAR) begin
      k = TK_OPEN;
    end else if (prec(c) != 2'd0) begin
      k = TK_OPER;
    end else begin
      k = TK_BAD;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/infix_to_prefix_converter.sv =====
// Loading: one word per cycle while the front is idle; non-last words give no result.
// After a last word: the front scans the stored chars backward; the back handles each operand,
// ')', operator and '(' with its popped stack entries, then flushes the stack at the end
// marker and emits the result words.
// Input is taken again as soon as the end marker enters the token queue.
// Reset (rst_ni low, async): counts, flags, states and queue cleared; stores not cleared.
`default_nettype none

module infix_to_prefix_converter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input words
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] ch
  input  wire logic        s_axis_tlast_i,   // last char of the expression
  // result words
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // [7:0] out_char
  output logic [1:0]       m_axis_tuser_o,   // [0] present, [1] err
  output logic             m_axis_tlast_o    // end_of_run
);

  // Front: stores chars, then on tlast reads the store backward, classifies each
  // char and queues tokens (blanks dropped, unknown bytes flagged). An end token
  // carries the front's error flag (store overflow, unknown char).
  i2p_pkg::token_t             q_din, q_dout;
  logic                        q_push, q_pop, q_empty, q_full;
  logic [i2p_pkg::QCW-1:0]     q_count;

  i2p_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_ch_i    (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .q_push_o   (q_push),
    .q_tok_o    (q_din),
    .q_full_i   (q_full),
    .q_count_i  (q_count)
  );

  // Short token queue; lets the front start loading the next expression
  // while the back still converts and emits the current one.
  i2p_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .din_i   (q_din),
    .pop_i   (q_pop),
    .dout_o  (q_dout),
    .empty_o (q_empty),
    .full_o  (q_full),
    .count_o (q_count)
  );

  // Back: operator stack with cached top and an output stack, both in RAM
  // with registered reads. After the end token it flushes the operator stack,
  // then pops the output stack into the output register, which decouples
  // the result side.
  i2p_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_tok_i       (q_dout),
    .q_empty_i     (q_empty),
    .q_pop_o       (q_pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_char_o    (m_axis_tdata_o),
    .out_present_o (m_axis_tuser_o[0]),
    .out_err_o     (m_axis_tuser_o[1]),
    .out_last_o    (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/i2p_fifo.sv =====
`default_nettype none

module i2p_fifo (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push_i,
  input  wire i2p_pkg::token_t          din_i,
  input  wire logic                     pop_i,
  output i2p_pkg::token_t               dout_o,
  output logic                          empty_o,
  output logic                          full_o,
  output logic [i2p_pkg::QCW-1:0]       count_o
);

  i2p_pkg::token_t                 mem_q [i2p_pkg::QDEPTH];
  logic [i2p_pkg::QAW-1:0]         wptr_q, wptr_d;
  logic [i2p_pkg::QAW-1:0]         rptr_q, rptr_d;
  logic [i2p_pkg::QCW-1:0]         cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == i2p_pkg::QCW'(i2p_pkg::QDEPTH));
  assign count_o = cnt_q;
  assign dout_o  = mem_q[rptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= din_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/i2p_front.sv =====
`default_nettype none

module i2p_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [7:0]               in_ch_i,
  input  wire logic                     in_last_i,
  output logic                          q_push_o,
  output i2p_pkg::token_t               q_tok_o,
  input  wire logic                     q_full_i,
  input  wire logic [i2p_pkg::QCW-1:0]  q_count_i
);

  typedef enum logic [1:0] {
    F_LOAD = 2'b01,
    F_SCAN = 2'b10
  } fstate_e;

  fstate_e                   state_q, state_d;
  logic [i2p_pkg::CW-1:0]    cnt_q, cnt_d;
  logic [i2p_pkg::CW-1:0]    idx_q, idx_d;
  logic                      pend_q, pend_d;
  logic                      err_q, err_d;
  logic [7:0]                store_q [i2p_pkg::DEPTH];
  logic [7:0]                rd_q;
  logic                      we;
  logic [i2p_pkg::AW-1:0]    waddr, raddr;
  logic [i2p_pkg::CW-1:0]    idx_m1;
  logic [i2p_pkg::QCW:0]     used;
  i2p_pkg::tok_kind_e        kind;

  assign in_ready_o = (state_q == F_LOAD);
  assign idx_m1     = idx_q - 1'b1;
  assign raddr      = idx_m1[i2p_pkg::AW-1:0];
  assign waddr      = cnt_q[i2p_pkg::AW-1:0];
  assign used       = {1'b0, q_count_i} + (i2p_pkg::QCW+1)'(pend_q);
  assign kind       = i2p_pkg::classify(rd_q);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    pend_d   = 1'b0;
    err_d    = err_q;
    we       = 1'b0;
    q_push_o = 1'b0;
    q_tok_o  = '{kind: kind, ch: rd_q};
    unique case (state_q)
      F_LOAD: begin
        if (in_valid_i) begin
          if (cnt_q < i2p_pkg::CW'(i2p_pkg::DEPTH)) begin
            we    = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end else begin
            err_d = 1'b1;
          end
          if (in_last_i) begin
            idx_d   = cnt_d;
            state_d = F_SCAN;
          end
        end
      end
      F_SCAN: begin
        // read one char per cycle, backward, while queue slots are free
        if (idx_q != '0 && used < (i2p_pkg::QCW+1)'(i2p_pkg::QDEPTH)) begin
          pend_d = 1'b1;
          idx_d  = idx_m1;
        end
        if (pend_q) begin
          if (kind == i2p_pkg::TK_BAD) begin
            err_d = 1'b1;
          end else if (kind != i2p_pkg::TK_BLANK) begin
            q_push_o = 1'b1;
          end
        end else if (idx_q == '0 && !q_full_i) begin
          q_push_o = 1'b1;
          q_tok_o  = '{kind: i2p_pkg::TK_END, ch: {7'd0, err_q}};
          cnt_d    = '0;
          err_d    = 1'b0;
          state_d  = F_LOAD;
        end
      end
      default: state_d = F_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_LOAD;
      cnt_q   <= '0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[waddr] <= in_ch_i;
    end
    rd_q <= store_q[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/i2p_back.sv =====
`default_nettype none

module i2p_back (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire i2p_pkg::token_t          q_tok_i,
  input  wire logic                     q_empty_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [7:0]                    out_char_o,
  output logic                          out_present_o,
  output logic                          out_err_o,
  output logic                          out_last_o
);

  typedef enum logic [6:0] {
    B_TOKEN    = 7'b0000001,
    B_OPER_CHK = 7'b0000010,
    B_OPEN_POP = 7'b0000100,
    B_FLUSH    = 7'b0001000,
    B_POP_WAIT = 7'b0010000,
    B_EMIT_RD  = 7'b0100000,
    B_EMIT_WR  = 7'b1000000
  } bstate_e;

  bstate_e                   state_q, state_d;
  bstate_e                   ret_q, ret_d;
  logic [i2p_pkg::CW-1:0]    top_q, top_d;
  logic [i2p_pkg::CW-1:0]    ocnt_q, ocnt_d;
  logic                      err_q, err_d;
  logic [7:0]                topv_q, topv_d;
  logic [7:0]                cur_q, cur_d;
  logic                      ov_q, ov_d;
  logic [7:0]                ochar_q, ochar_d;
  logic                      opres_q, opres_d;
  logic                      oerr_q, oerr_d;
  logic                      olast_q, olast_d;

  logic [7:0]                op_mem_q [i2p_pkg::DEPTH];
  logic [7:0]                out_mem_q [i2p_pkg::DEPTH];
  logic [7:0]                op_rd_q, out_rd_q;
  logic                      op_req, out_req, pop, op_we, out_we, out_free;
  logic [7:0]                op_wdata, out_wdata;
  logic [i2p_pkg::CW-1:0]    op_rptr, out_rptr;
  logic [i2p_pkg::AW-1:0]    op_raddr, out_raddr;

  assign out_valid_o   = ov_q;
  assign out_char_o    = ochar_q;
  assign out_present_o = opres_q;
  assign out_err_o     = oerr_q;
  assign out_last_o    = olast_q;

  assign out_free  = !ov_q || out_ready_i;
  // entry below the cached top, and the output stack's top
  assign op_rptr   = top_q - i2p_pkg::CW'(2);
  assign op_raddr  = op_rptr[i2p_pkg::AW-1:0];
  assign out_rptr  = ocnt_q - 1'b1;
  assign out_raddr = out_rptr[i2p_pkg::AW-1:0];

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    top_d     = top_q;
    ocnt_d    = ocnt_q;
    err_d     = err_q;
    topv_d    = topv_q;
    cur_d     = cur_q;
    ov_d      = ov_q && !out_ready_i;
    ochar_d   = ochar_q;
    opres_d   = opres_q;
    oerr_d    = oerr_q;
    olast_d   = olast_q;
    q_pop_o   = 1'b0;
    op_req    = 1'b0;
    out_req   = 1'b0;
    pop       = 1'b0;
    op_wdata  = cur_q;
    out_wdata = topv_q;
    op_we     = 1'b0;
    out_we    = 1'b0;

    unique case (state_q)
      B_TOKEN: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          unique case (q_tok_i.kind)
            i2p_pkg::TK_OPERAND: begin
              out_req   = 1'b1;
              out_wdata = q_tok_i.ch;
            end
            i2p_pkg::TK_CLOSE: begin
              op_req   = 1'b1;
              op_wdata = q_tok_i.ch;
            end
            i2p_pkg::TK_OPER: begin
              cur_d   = q_tok_i.ch;
              state_d = B_OPER_CHK;
            end
            i2p_pkg::TK_OPEN: state_d = B_OPEN_POP;
            i2p_pkg::TK_END: begin
              err_d   = err_q | q_tok_i.ch[0];
              state_d = B_FLUSH;
            end
            default: ;
          endcase
        end
      end
      B_OPER_CHK: begin
        if (top_q != '0 && i2p_pkg::prec(topv_q) > i2p_pkg::prec(cur_q)) begin
          out_req = 1'b1;
          pop     = 1'b1;
          ret_d   = B_OPER_CHK;
        end else begin
          op_req  = 1'b1;
          state_d = B_TOKEN;
        end
      end
      B_OPEN_POP: begin
        if (top_q == '0) begin
          err_d   = 1'b1;
          state_d = B_TOKEN;
        end else begin
          pop = 1'b1;
          if (topv_q == i2p_pkg::CH_RPAR) begin
            ret_d = B_TOKEN;
          end else begin
            out_req = 1'b1;
            ret_d   = B_OPEN_POP;
          end
        end
      end
      B_FLUSH: begin
        if (top_q == '0) begin
          state_d = B_EMIT_RD;
        end else begin
          pop   = 1'b1;
          ret_d = B_FLUSH;
          if (topv_q == i2p_pkg::CH_RPAR) begin
            err_d = 1'b1;
          end else begin
            out_req = 1'b1;
          end
        end
      end
      B_POP_WAIT: begin
        if (top_q != '0) begin
          topv_d = op_rd_q;
        end
        state_d = ret_q;
      end
      B_EMIT_RD: begin
        if (out_free) begin
          if (ocnt_q == '0) begin
            ov_d    = 1'b1;
            ochar_d = 8'd0;
            opres_d = 1'b0;
            oerr_d  = err_q;
            olast_d = 1'b1;
            err_d   = 1'b0;
            state_d = B_TOKEN;
          end else begin
            ocnt_d  = out_rptr;
            state_d = B_EMIT_WR;
          end
        end
      end
      B_EMIT_WR: begin
        ov_d    = 1'b1;
        ochar_d = out_rd_q;
        opres_d = 1'b1;
        oerr_d  = err_q;
        olast_d = (ocnt_q == '0);
        if (ocnt_q == '0) begin
          err_d   = 1'b0;
          state_d = B_TOKEN;
        end else begin
          state_d = B_EMIT_RD;
        end
      end
      default: state_d = B_TOKEN;
    endcase

    if (pop) begin
      top_d   = top_q - 1'b1;
      state_d = B_POP_WAIT;
    end
    if (op_req) begin
      if (top_q >= i2p_pkg::CW'(i2p_pkg::DEPTH)) begin
        err_d = 1'b1;
      end else begin
        op_we  = 1'b1;
        top_d  = top_q + 1'b1;
        topv_d = op_wdata;
      end
    end
    if (out_req) begin
      if (ocnt_q >= i2p_pkg::CW'(i2p_pkg::OUT_LIMIT)) begin
        err_d = 1'b1;
      end else begin
        out_we = 1'b1;
        ocnt_d = ocnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_TOKEN;
      ret_q   <= B_TOKEN;
      top_q   <= '0;
      ocnt_q  <= '0;
      err_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      top_q   <= top_d;
      ocnt_q  <= ocnt_d;
      err_q   <= err_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    topv_q  <= topv_d;
    cur_q   <= cur_d;
    ochar_q <= ochar_d;
    opres_q <= opres_d;
    oerr_q  <= oerr_d;
    olast_q <= olast_d;
  end

  always_ff @(posedge clk_i) begin
    if (op_we) begin
      op_mem_q[top_q[i2p_pkg::AW-1:0]] <= op_wdata;
    end
    op_rd_q <= op_mem_q[op_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (out_we) begin
      out_mem_q[ocnt_q[i2p_pkg::AW-1:0]] <= out_wdata;
    end
    out_rd_q <= out_mem_q[out_raddr];
  end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned RANDOM_CHARS = 40;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned MAX_GAP      = 16;

  // one result word as the block should present it
  typedef struct packed {
    logic [7:0] out_char;
    logic       present;
    logic       err;
    logic       end_of_run;
  } prefix_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       s_axis_tvalid_i;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i;   // [7:0] ch
  logic       s_axis_tlast_i;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i;
  logic [7:0] m_axis_tdata_o;   // [7:0] out_char
  logic [1:0] m_axis_tuser_o;   // [0] present, [1] err
  logic       m_axis_tlast_o;

  infix_to_prefix_converter u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state: chars of the current expression and its error flag
  logic [7:0]   expr_chars[$];
  bit           expr_err;
  logic [7:0]   oper_stack[$];
  logic [7:0]   prefix_stack[$];
  prefix_word_t prefix_words_due[$];

  int unsigned mismatch_count = 0;
  int unsigned sink_hold      = 0;   // long receiver stall, counted down by the sink
  bit          source_burst   = 1'b0;
  bit          sink_burst     = 1'b0;

  function automatic int unsigned op_rank(input logic [7:0] c);
    case (c)
      i2p_pkg::CH_DOLLAR:                                  return 3;
      i2p_pkg::CH_STAR, i2p_pkg::CH_SLASH, i2p_pkg::CH_PCT: return 2;
      i2p_pkg::CH_PLUS, i2p_pkg::CH_MINUS:                 return 1;
      default:                                             return 0;
    endcase
  endfunction

  function automatic bit is_alnum(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function void emit_char(input logic [7:0] c);
    if (prefix_stack.size() >= i2p_pkg::OUT_LIMIT) expr_err = 1'b1;
    else prefix_stack.push_back(c);
  endfunction

  function void stack_oper(input logic [7:0] c);
    if (oper_stack.size() >= i2p_pkg::DEPTH) expr_err = 1'b1;
    else oper_stack.push_back(c);
  endfunction

  // right-to-left scan of the stored expression, then queue the prefix words
  function void predict_prefix();
    int         i;
    logic [7:0] c;
    logic [7:0] o;
    bit         matched;
    oper_stack.delete();
    prefix_stack.delete();
    for (i = expr_chars.size() - 1; i >= 0; i--) begin
      c = expr_chars[i];
      if (c == i2p_pkg::CH_SPACE || c == i2p_pkg::CH_TAB) begin
      end else if (is_alnum(c)) begin
        emit_char(c);
      end else if (c == i2p_pkg::CH_RPAR) begin
        stack_oper(c);
      end else if (op_rank(c) != 0) begin
        while (oper_stack.size() > 0 && op_rank(oper_stack[$]) > op_rank(c))
          emit_char(oper_stack.pop_back());
        stack_oper(c);
      end else if (c == i2p_pkg::CH_LPAR) begin
        matched = 1'b0;
        while (oper_stack.size() > 0 && !matched) begin
          o = oper_stack.pop_back();
          if (o == i2p_pkg::CH_RPAR) matched = 1'b1;
          else emit_char(o);
        end
        if (!matched) expr_err = 1'b1;
      end else begin
        expr_err = 1'b1;
      end
    end
    while (oper_stack.size() > 0) begin
      o = oper_stack.pop_back();
      if (o == i2p_pkg::CH_RPAR) expr_err = 1'b1;
      else emit_char(o);
    end
    if (prefix_stack.size() == 0) begin
      prefix_words_due.push_back('{8'h00, 1'b0, expr_err, 1'b1});
    end else begin
      for (i = prefix_stack.size() - 1; i >= 0; i--)
        prefix_words_due.push_back('{prefix_stack[i], 1'b1, expr_err, i == 0});
    end
    expr_chars.delete();
    expr_err = 1'b0;
  endfunction

  function void take_char(input logic [7:0] c, input logic is_final);
    if (expr_chars.size() < i2p_pkg::DEPTH) expr_chars.push_back(c);
    else expr_err = 1'b1;
    if (is_final) predict_prefix();
  endfunction

  // one word on the input side; valid stays high across back-to-back words
  task automatic send_char(input logic [7:0] c, input logic is_final);
    int unsigned gap;
    gap = source_burst ? 0 : $urandom_range(0, MAX_GAP);
    repeat (gap) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    s_axis_tlast_i  <= is_final;
    do @(posedge clk_i); while (!s_axis_tready_o);
    take_char(c, is_final);
  endtask

  task automatic send_expr(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // input goes idle first so the last word is not taken twice
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (prefix_words_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_operand();
    int unsigned r;
    r = $urandom_range(0, 61);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("A" + r - 10);
    return 8'("a" + r - 36);
  endfunction

  function automatic logic [7:0] rand_oper();
    case ($urandom_range(0, 5))
      0:       return i2p_pkg::CH_DOLLAR;
      1:       return i2p_pkg::CH_STAR;
      2:       return i2p_pkg::CH_SLASH;
      3:       return i2p_pkg::CH_PCT;
      4:       return i2p_pkg::CH_PLUS;
      default: return i2p_pkg::CH_MINUS;
    endcase
  endfunction

  function automatic string rand_pad();
    case ($urandom_range(0, 9))
      0:       return " ";
      1:       return "\t";
      default: return "";
    endcase
  endfunction

  // well-formed infix text, nested parentheses up to the given level
  function automatic string rand_infix(input int unsigned nest);
    string       s;
    int unsigned terms;
    int unsigned k;
    s = "";
    terms = $urandom_range(1, 4);
    for (k = 0; k < terms; k++) begin
      if (k > 0) s = $sformatf("%s%s%c%s", s, rand_pad(), rand_oper(), rand_pad());
      if (nest > 0 && $urandom_range(0, 3) == 0)
        s = {s, "(", rand_infix(nest - 1), ")"};
      else
        s = $sformatf("%s%c", s, rand_operand());
    end
    return s;
  endfunction

  task automatic test_precedence();
    send_expr("a+b*c");
    send_expr("a$b$c");
    send_expr("(a-b)/c%d");
    send_expr("9*Z");
  endtask

  task automatic test_special_cases();
    send_expr("x");
    send_expr(" ");
    send_expr("\t");
    send_char(8'h00, 1'b0);
    send_char("a", 1'b0);
    send_char(8'hFF, 1'b1);
    send_char(8'h80, 1'b1);
    send_expr("(a+b");
    send_expr("a+b)");
  endtask

  // store filled past its end: the extra chars are dropped and flagged
  task automatic test_store_limits();
    int i;
    for (i = 0; i < i2p_pkg::DEPTH + 6; i++)
      send_char((i % 2) ? i2p_pkg::CH_PLUS : rand_operand(), i == i2p_pkg::DEPTH + 5);
    drain_results();
  endtask

  // receiver stalls while whole expressions keep arriving back to back
  task automatic test_backpressure();
    int i;
    source_burst = 1'b1;
    sink_hold    = 400;
    for (i = 0; i < 4; i++) send_expr("(a+b)*c-d$e/f%g");
    drain_results();
    source_burst = 1'b0;
  endtask

  task automatic test_random_mix();
    int unsigned chars_sent;
    int unsigned kind;
    int unsigned n;
    int unsigned i;
    string       s;
    chars_sent = 0;
    while (chars_sent < RANDOM_CHARS) begin
      source_burst = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        s = rand_infix(2);
        send_expr(s);
        chars_sent += s.len();
      end else if (kind < 17) begin
        // broken: a parenthesis without its partner
        s = ($urandom_range(0, 1) != 0) ? {"(", rand_infix(1)} : {rand_infix(1), ")"};
        send_expr(s);
        chars_sent += s.len();
      end else begin
        n = $urandom_range(1, 10);
        for (i = 0; i < n; i++) send_char(8'($urandom_range(0, 255)), i == n - 1);
        chars_sent += n;
      end
    end
    source_burst = 1'b0;
  endtask

  // sink: random ready gaps, the long hold, and the comparison of each word
  initial begin
    int unsigned  pause;
    int unsigned  words_seen;
    prefix_word_t due;
    pause      = 0;
    words_seen = 0;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (prefix_words_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected word: ch=%h user=%b last=%b",
                     m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        end else begin
          due = prefix_words_due.pop_front();
          if (due.out_char !== m_axis_tdata_o || due.present !== m_axis_tuser_o[0] ||
              due.err !== m_axis_tuser_o[1] || due.end_of_run !== m_axis_tlast_o) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch at %0t: exp ch=%h p=%b e=%b l=%b, got ch=%h p=%b e=%b l=%b",
                       $realtime, due.out_char, due.present, due.err, due.end_of_run,
                       m_axis_tdata_o, m_axis_tuser_o[0], m_axis_tuser_o[1],
                       m_axis_tlast_o);
          end
        end
        words_seen++;
        if (words_seen % 24 == 0) sink_burst = ($urandom_range(0, 3) == 0);
        pause = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (sink_hold > 0) begin
        m_axis_tready_i <= 1'b0;
        sink_hold--;
      end else if (pause > 0) begin
        m_axis_tready_i <= 1'b0;
        pause--;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    expr_err        = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'h00;
    s_axis_tlast_i  = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_precedence();
    test_special_cases();
    test_store_limits();
    test_backpressure();
    test_random_mix();

    drain_results();
    repeat (40) @(posedge clk_i);

    if (mismatch_count == 0 && prefix_words_due.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
